// File: rtl/bsp_pkg.sv
// Shared types and constants for the boundary strength profile core.
// Used by bsp_div, boundary_strength_profile_core and bsp_chk.
package bsp_pkg;

  localparam int unsigned VAL_W     = 24;  // profile value, Q.8 signed
  localparam int unsigned MAG_W     = VAL_W - 1;
  localparam int unsigned CHG_W     = 17;  // degree of change, Q0.16, 0..65536
  localparam int unsigned CSUM_W    = CHG_W + 1;
  localparam int unsigned STR_W     = 32;  // strength, Q.16 unsigned
  localparam int unsigned SUM_W     = 24;  // a + b of two nonnegative values
  localparam int unsigned REM_W     = SUM_W + 1;
  localparam int unsigned DIV_STEPS = CHG_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned PROD_W    = MAG_W + CSUM_W;
  localparam int unsigned FRAC_SH   = 8;   // Q.24 product back to Q.16

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NEXT,
    ST_EMIT_PREV,
    ST_EMIT_CUR
  } bsp_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bsp_div_stat_t;

endpackage

// File: rtl/bsp_div.sv
// Restoring divider: quotient = diff * 2^16 / sum, one quotient bit a cycle.
// Requires diff <= sum and sum != 0. Depends on bsp_pkg.
module bsp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bsp_pkg::SUM_W-1:0]    diff,
  input  logic [bsp_pkg::SUM_W-1:0]    sum,
  output logic [bsp_pkg::CHG_W-1:0]    quotient,
  output bsp_pkg::bsp_div_stat_t       stat
);
  import bsp_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CHG_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  assign ge      = rem_r >= {1'b0, sum_r};
  assign rem_sub = ge ? (rem_r - {1'b0, sum_r}) : rem_r;

  always_comb begin
    rem_nxt  = rem_r;
    sum_nxt  = sum_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, diff};
      sum_nxt  = sum;
      cnt_nxt  = CNT_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[CHG_W-2:0], ge};
      // remainder stays below sum, so the shift cannot overflow
      rem_nxt = {rem_sub[REM_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sum_r <= sum_nxt;
    q_r   <= q_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/boundary_strength_profile_core.sv
// Top level of the boundary strength profile core.
// Depends on bsp_pkg and bsp_div.
//
// Takes one Q.8 profile value per beat and gives the boundary strength of each value
// in Q.16, one value late: a beat yields the strength of the value before it, and a
// beat marked tlast also yields its own strength, tagged with tlast. When the degree of
// change needs a division, a beat passes through accept, 17 steps of the bit-serial
// divider (one quotient bit per cycle), its done strobe, dispatch and up to two result
// loads; when it does not, through accept, dispatch and up to two result loads. A new
// beat is taken only in idle, once the last has retired. Results leave through a
// one-entry output register; a stalled output holds the sequencer at its result load.
module boundary_strength_profile_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // [23:0] profile_value
  input  logic                        in_tlast,   // is_last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] strength
  output logic                        out_tlast   // last_of_run
);
  import bsp_pkg::*;

  bsp_state_t       state_r, state_nxt;
  logic [VAL_W-1:0] prev_val_r, prev_val_nxt;
  logic [CHG_W-1:0] prev_chg_r, prev_chg_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [VAL_W-1:0] cur_val_r, cur_val_nxt;
  logic             cur_last_r, cur_last_nxt;
  logic [CHG_W-1:0] chg_r, chg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STR_W-1:0] out_str_r, out_str_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire, out_free, emit;
  logic [VAL_W-1:0] op_a;
  logic [SUM_W-1:0] op_sum, op_diff;
  logic             op_skip;
  logic             div_start;
  logic [CHG_W-1:0] div_q;
  bsp_div_stat_t    div_stat;

  logic [VAL_W-1:0]  mul_val;
  logic [CSUM_W-1:0] mul_csum;
  logic [PROD_W-1:0] product;
  logic [STR_W-1:0]  strength;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Operands of the degree of change; the first value compares against zero.
  assign op_a    = have_prev_r ? prev_val_r : '0;
  assign op_sum  = {1'b0, op_a[MAG_W-1:0]} + {1'b0, in_tdata[MAG_W-1:0]};
  assign op_diff = (op_a[MAG_W-1:0] >= in_tdata[MAG_W-1:0])
                 ? {1'b0, op_a[MAG_W-1:0] - in_tdata[MAG_W-1:0]}
                 : {1'b0, in_tdata[MAG_W-1:0] - op_a[MAG_W-1:0]};
  assign op_skip   = op_a[VAL_W-1] || in_tdata[VAL_W-1] || (op_sum == '0);
  assign div_start = in_fire && !op_skip;

  bsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .diff     (op_diff),
    .sum      (op_sum),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Shared multiplier: pending value with both changes, or current value alone.
  always_comb begin
    if (state_r == ST_EMIT_PREV) begin
      mul_val  = prev_val_r;
      mul_csum = {1'b0, prev_chg_r} + {1'b0, chg_r};
    end else begin
      mul_val  = cur_val_r;
      mul_csum = {1'b0, chg_r};
    end
  end

  assign product  = PROD_W'(mul_val[MAG_W-1:0]) * PROD_W'(mul_csum);
  assign strength = (mul_val[VAL_W-1] || mul_val == '0)
                  ? '0 : product[FRAC_SH +: STR_W];

  always_comb begin
    state_nxt     = state_r;
    prev_val_nxt  = prev_val_r;
    prev_chg_nxt  = prev_chg_r;
    have_prev_nxt = have_prev_r;
    cur_val_nxt   = cur_val_r;
    cur_last_nxt  = cur_last_r;
    chg_nxt       = chg_r;
    emit          = 1'b0;
    out_last_nxt  = out_last_r;
    out_str_nxt   = out_str_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cur_val_nxt  = in_tdata;
          cur_last_nxt = in_tlast;
          chg_nxt      = '0;
          state_nxt    = op_skip ? ST_NEXT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          chg_nxt   = div_q;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (have_prev_r)     state_nxt = ST_EMIT_PREV;
        else if (cur_last_r) state_nxt = ST_EMIT_CUR;
        else                 state_nxt = ST_IDLE;
      end
      ST_EMIT_PREV: begin
        if (out_free) begin
          emit         = 1'b1;
          out_str_nxt  = strength;
          out_last_nxt = 1'b0;
          state_nxt    = cur_last_r ? ST_EMIT_CUR : ST_IDLE;
        end
      end
      ST_EMIT_CUR: begin
        if (out_free) begin
          emit         = 1'b1;
          out_str_nxt  = strength;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Retire the item: hold it as pending, or close the run after last.
    if (state_r != ST_IDLE && state_nxt == ST_IDLE) begin
      if (cur_last_r) begin
        prev_val_nxt  = '0;
        prev_chg_nxt  = '0;
        have_prev_nxt = 1'b0;
      end else begin
        prev_val_nxt  = cur_val_r;
        prev_chg_nxt  = chg_r;
        have_prev_nxt = 1'b1;
      end
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_val_r  <= '0;
      prev_chg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      prev_val_r  <= prev_val_nxt;
      prev_chg_r  <= prev_chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_val_r  <= cur_val_nxt;
    cur_last_r <= cur_last_nxt;
    chg_r      <= chg_nxt;
    out_str_r  <= out_str_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_str_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/bsp_chk.sv
// Port-level checker for boundary_strength_profile_core, attached by bind.
// Depends on nothing but the top level's ports.
module bsp_port_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // One item at a time: drop ready right after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high the cycle after an accepted beat");

  // A result never appears the cycle right after an input beat is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared directly after input accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind boundary_strength_profile_core bsp_port_chk u_bsp_port_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: tb/bsp_chk.sv
// Scoreboard for the boundary strength profile core: predicts strengths from accepted input
// beats and compares them with the result beats, oldest first.
// Depends on bsp_pkg for field widths.
module bsp_chk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [bsp_pkg::VAL_W-1:0] in_tdata,   // [23:0] profile_value
  input  logic                      in_tlast,   // is_last
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [bsp_pkg::STR_W-1:0] out_tdata,  // [31:0] strength
  input  logic                      out_tlast,  // last_of_run
  output int                        fail_count,
  output int                        outstanding
);
  import bsp_pkg::*;

  typedef struct {
    logic [STR_W-1:0] strength;
    logic             last_of_run;
  } strength_beat_t;

  strength_beat_t          strength_exp_q[$];
  logic signed [VAL_W-1:0] held_value;
  logic [CHG_W-1:0]        held_change;
  logic                    value_pending;

  // |a-b| / (a+b) in Q0.16, truncated; zero for a zero sum or a negative operand
  function automatic logic [CHG_W-1:0] change_q16(logic signed [VAL_W-1:0] a,
                                                  logic signed [VAL_W-1:0] b);
    logic [VAL_W:0] total;
    logic [VAL_W:0] gap;
    logic [63:0]    scaled;
    if (a < 0 || b < 0) return '0;
    total = {1'b0, a} + {1'b0, b};
    if (total == 0) return '0;
    gap = (a > b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
    scaled = {39'd0, gap} << 16;
    return CHG_W'(scaled / {39'd0, total});
  endfunction

  // value (Q.8) times change sum (Q0.16), back to Q.16; zero for a nonpositive value
  function automatic logic [STR_W-1:0] strength_q16(logic signed [VAL_W-1:0] value,
                                                    logic [CSUM_W-1:0] change_sum);
    logic [63:0] prod;
    if (value <= 0) return '0;
    prod = {40'd0, value} * {46'd0, change_sum};
    return prod[STR_W+FRAC_SH-1:FRAC_SH];
  endfunction

  function automatic void predict_beat(logic signed [VAL_W-1:0] v, logic is_last);
    logic [CHG_W-1:0] chg;
    strength_beat_t   beat;
    if (value_pending) begin
      chg = change_q16(held_value, v);
      beat.strength    = strength_q16(held_value, {1'b0, held_change} + {1'b0, chg});
      beat.last_of_run = 1'b0;
      strength_exp_q.insert(strength_exp_q.size(), beat);
    end else begin
      chg = change_q16('0, v);
    end
    if (is_last) begin
      beat.strength    = strength_q16(v, {1'b0, chg});
      beat.last_of_run = 1'b1;
      strength_exp_q.insert(strength_exp_q.size(), beat);
      held_value    = '0;
      held_change   = '0;
      value_pending = 1'b0;
    end else begin
      held_value    = v;
      held_change   = chg;
      value_pending = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    strength_beat_t want;
    if (!rst_n) begin
      held_value    = '0;
      held_change   = '0;
      value_pending = 1'b0;
      fail_count    = 0;
      strength_exp_q.delete();
    end else begin
      // results first: a beat accepted at this edge cannot have produced one yet
      if (out_tvalid && out_tready) begin
        if (strength_exp_q.size() == 0) begin
          $error("unexpected result beat: strength %0h last_of_run %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = strength_exp_q.pop_front();
          if (out_tdata !== want.strength) begin
            $error("strength mismatch: expected %0h, got %0h", want.strength, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, got %0b", want.last_of_run, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_beat(in_tdata, in_tlast);
    end
    outstanding = strength_exp_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the boundary strength profile testbench: clock, reset, beat stimulus and verdict.
// Depends on bsp_pkg, boundary_strength_profile_core and the bsp_chk scoreboard.
module tb_top;
  import bsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata;   // [23:0] profile_value
  logic             in_tlast;   // is_last
  logic             out_tvalid;
  logic             out_tready;
  logic [STR_W-1:0] out_tdata;  // [31:0] strength
  logic             out_tlast;  // last_of_run

  int               fail_count;
  int               outstanding;
  int               cycle_count;
  int               idle_pct;
  int               stall_pct;
  int               hold_left;
  int               hold_req_cnt;
  int               hold_ack_cnt;
  int               beats_sent;
  logic [VAL_W-1:0] last_sent;

  boundary_strength_profile_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bsp_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[boundary_strength_profile_core] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_tready   = 1'b0;
    hold_left    = 0;
    hold_ack_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_left    = HOLD_CYCLES;
        hold_ack_cnt = hold_req_cnt;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value(logic [VAL_W-1:0] prev);
    case ($urandom_range(11))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return '0;
      3:       return prev;
      4:       return VAL_W'($urandom_range(1, 255));
      5:       return VAL_W'(-int'($urandom_range(1, 1000)));
      6, 7, 8: return {1'b0, 23'($urandom())};
      default: return VAL_W'($urandom());
    endcase
  endfunction

  task automatic send_beat(input logic [VAL_W-1:0] v, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tlast  = is_last;
    do @(posedge clk); while (!in_tready);
    last_sent = v;
    beats_sent++;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_beat(pick_value(last_sent), i == len - 1);
  endtask

  // drop valid and hold until every predicted strength has left the block
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    rst_n        = 1'b0;
    hold_req_cnt = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    beats_sent   = 0;
    last_sent    = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // single-value runs: positive maximum, zero, most negative
    send_beat(24'h7FFFFF, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h800000, 1'b1);
    // equal neighbors, zero sums, negatives next to positives, extremes
    send_beat(24'h000001, 1'b0);
    send_beat(24'h000001, 1'b0);
    send_beat(24'h7FFFFF, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'hFFFFFF, 1'b0);
    send_beat(24'h000005, 1'b0);
    send_beat(24'h800000, 1'b0);
    send_beat(24'h7FFFFF, 1'b1);
    // large swings between maximum and minimum positive
    send_beat(24'h7FFFFF, 1'b0);
    send_beat(24'h000001, 1'b0);
    send_beat(24'h7FFFFF, 1'b1);
    // run starting with a negative, ending on a zero
    send_beat(24'hFFFF00, 1'b0);
    send_beat(24'h000100, 1'b0);
    send_beat(24'h000200, 1'b0);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000064, 1'b0);
    send_beat(24'h0000C8, 1'b1);

    // back-pressure: hold the output while a run keeps coming, then drain
    @(posedge clk);
    hold_req_cnt++;
    send_run(12);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 81; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      for (int n = 0; n < 100; ) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        send_run(len);
        n += len;
      end
      if (phase == 1) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[boundary_strength_profile_core] OK");
    end else begin
      $display("[boundary_strength_profile_core] ERROR");
    end
    $finish;
  end

endmodule
